/* sv/mava_pkg.sv */
// Package: shared types and constants for the mesh area/volume accumulator
`timescale 1ns / 1ps
package mava_pkg;

    localparam int CoordW  = 16;
    localparam int EdgeW   = 17;
    localparam int AreaW   = 63;
    localparam int VolW    = 64;
    localparam int CountW  = 21;
    localparam int NormW   = 35;
    localparam int MagW    = 34;
    localparam int SqW     = 70;
    localparam int RootW   = 35;
    localparam int RemW    = 38;
    localparam int DotW    = 54;
    localparam int MulAW   = 36;
    localparam int MulBW   = 18;
    localparam int ProdW   = 54;
    localparam int DivSteps = 32;

    typedef struct packed {
        logic                       first;
        logic signed [EdgeW-1:0]    e0x;
        logic signed [EdgeW-1:0]    e0y;
        logic signed [EdgeW-1:0]    e0z;
        logic signed [EdgeW-1:0]    e1x;
        logic signed [EdgeW-1:0]    e1y;
        logic signed [EdgeW-1:0]    e1z;
        logic signed [CoordW-1:0]   ax;
        logic signed [CoordW-1:0]   ay;
        logic signed [CoordW-1:0]   az;
    } t_tri;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_UPD,
        S_ITER,
        S_FIN
    } t_state;

    typedef enum logic [3:0] {
        M_NX0, M_NX1, M_NY0, M_NY1, M_NZ0, M_NZ1,
        M_SXL, M_SXH, M_SYL, M_SYH, M_SZL, M_SZH,
        M_DX, M_DY, M_DZ, M_NONE
    } t_step;

endpackage

/* sv/mesh_area_volume_accumulator_core.sv */
// Top level: triangle mesh area and signed volume accumulator
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | first flag, vertices a, b, c (Q7.8)
//  out     | output    | o_out_valid / i_out_ready  | area, volume, count, overflow flag
//  cfg     | input     | i_cfg_we                   | flip_winding
//
//  Each beat passes through the back end in turn: the shared 36x18 multiplier sequence
//  (normal, squared length, dot product), an update state, then the bit-serial square
//  root with the divide-by-six running alongside, a write-out state and an idle state
//  before the next beat is taken from the queue.
//  Synchronous active-low reset clears the queue, the accumulators and the flip bit.
//  A two-entry queue takes new beats while the back end works; a full output register
//  stalls the back end only at write-out.
`timescale 1ns / 1ps
module mesh_area_volume_accumulator_core import mava_pkg::*; #(
    parameter int MAX_TRIANGLES = 1048576
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_wdata,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_first_triangle,
    input  logic signed [CoordW-1:0] i_a_x,
    input  logic signed [CoordW-1:0] i_a_y,
    input  logic signed [CoordW-1:0] i_a_z,
    input  logic signed [CoordW-1:0] i_b_x,
    input  logic signed [CoordW-1:0] i_b_y,
    input  logic signed [CoordW-1:0] i_b_z,
    input  logic signed [CoordW-1:0] i_c_x,
    input  logic signed [CoordW-1:0] i_c_y,
    input  logic signed [CoordW-1:0] i_c_z,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [AreaW-1:0]         o_running_area,
    output logic signed [VolW-1:0]   o_running_volume,
    output logic [CountW-1:0]        o_triangle_count,
    output logic                     o_overflowed
);

    logic r_flip;
    logic w_tri_vld;
    t_tri w_tri;
    logic w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flip <= 1'b0;
        end else if (i_cfg_we) begin
            r_flip <= i_cfg_wdata;
        end
    end

    mava_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_first_triangle (i_first_triangle),
        .i_a_x            (i_a_x),
        .i_a_y            (i_a_y),
        .i_a_z            (i_a_z),
        .i_b_x            (i_b_x),
        .i_b_y            (i_b_y),
        .i_b_z            (i_b_z),
        .i_c_x            (i_c_x),
        .i_c_y            (i_c_y),
        .i_c_z            (i_c_z),
        .o_tri_vld        (w_tri_vld),
        .o_tri            (w_tri),
        .i_pop            (w_pop)
    );

    mava_back #(
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_flip           (r_flip),
        .i_tri_vld        (w_tri_vld),
        .i_tri            (w_tri),
        .o_pop            (w_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_running_area   (o_running_area),
        .o_running_volume (o_running_volume),
        .o_triangle_count (o_triangle_count),
        .o_overflowed     (o_overflowed)
    );

endmodule

/* sv/mava_front.sv */
// Front end: accepts triangle beats, forms edge vectors, two-entry queue to the back end
`timescale 1ns / 1ps
module mava_front import mava_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_first_triangle,
    input  logic signed [CoordW-1:0] i_a_x,
    input  logic signed [CoordW-1:0] i_a_y,
    input  logic signed [CoordW-1:0] i_a_z,
    input  logic signed [CoordW-1:0] i_b_x,
    input  logic signed [CoordW-1:0] i_b_y,
    input  logic signed [CoordW-1:0] i_b_z,
    input  logic signed [CoordW-1:0] i_c_x,
    input  logic signed [CoordW-1:0] i_c_y,
    input  logic signed [CoordW-1:0] i_c_z,
    output logic                     o_tri_vld,
    output t_tri                     o_tri,
    input  logic                     i_pop
);

    t_tri        r_q [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_cnt;
    t_tri        w_tri;
    logic        w_push;

    function automatic logic signed [EdgeW-1:0] sub(input logic signed [CoordW-1:0] p,
                                                    input logic signed [CoordW-1:0] q);
        return EdgeW'(p) - EdgeW'(q);
    endfunction

    always_comb begin
        w_tri.first = i_first_triangle;
        w_tri.e0x   = sub(i_b_x, i_a_x);
        w_tri.e0y   = sub(i_b_y, i_a_y);
        w_tri.e0z   = sub(i_b_z, i_a_z);
        w_tri.e1x   = sub(i_c_x, i_a_x);
        w_tri.e1y   = sub(i_c_y, i_a_y);
        w_tri.e1z   = sub(i_c_z, i_a_z);
        w_tri.ax    = i_a_x;
        w_tri.ay    = i_a_y;
        w_tri.az    = i_a_z;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign o_tri_vld  = (r_cnt != 2'd0);
    assign o_tri      = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_tri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end

endmodule

/* sv/mava_back.sv */
// Back end: shared multiplier sequence, bit-serial square root and divide-by-six, accumulators
`timescale 1ns / 1ps
module mava_back import mava_pkg::*; #(
    parameter int MAX_TRIANGLES = 1048576
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_flip,
    input  logic                     i_tri_vld,
    input  t_tri                     i_tri,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [AreaW-1:0]         o_running_area,
    output logic signed [VolW-1:0]   o_running_volume,
    output logic [CountW-1:0]        o_triangle_count,
    output logic                     o_overflowed
);

    localparam logic [CountW-1:0] CountMax =
        (MAX_TRIANGLES < (2 ** CountW - 1)) ? CountW'(MAX_TRIANGLES) : {CountW{1'b1}};
    localparam logic [5:0] IterLast = 6'(RootW - 1);

    t_state r_state, n_state;
    t_step  r_step, r_pstep;
    logic   r_pvld;
    logic signed [ProdW-1:0] r_prod;
    logic signed [NormW-1:0] r_nx, r_ny, r_nz;
    logic [SqW-1:0]          r_sq;
    logic signed [DotW-1:0]  r_dot;

    logic [SqW-1:0]          r_rad;
    logic [RemW-1:0]         r_rem;
    logic [RootW-1:0]        r_root;
    logic [VolW-1:0]         r_dq;
    logic [1:0]              r_drem;
    logic                    r_dneg;
    logic [5:0]              r_iter;

    logic [AreaW-1:0]        r_area;
    logic signed [VolW-1:0]  r_vol;
    logic [CountW-1:0]       r_cnt;
    logic                    r_sat;

    logic                    w_mul_done, w_iter_done, w_out_free;
    logic                    w_do_upd, w_do_fin;
    logic signed [MulAW-1:0] w_ma;
    logic signed [MulBW-1:0] w_mb;
    logic [MagW-1:0]         w_mx, w_my, w_mz, w_mag;
    logic signed [DotW:0]    w_contrib;
    logic signed [VolW:0]    w_vsum;
    logic signed [VolW-1:0]  w_vbase, w_vnew;
    logic                    w_vovf;
    logic [VolW-1:0]         w_vmag;
    logic [RemW-1:0]         w_trem, w_trial;
    logic [3:0]              w_dnext;
    logic [1:0]              w_qd;
    logic [AreaW:0]          w_asum;
    logic [AreaW-1:0]        w_anew;
    logic                    w_aovf;
    logic [VolW-1:0]         w_quot;

    function automatic logic [MagW-1:0] mag(input logic signed [NormW-1:0] v);
        logic signed [NormW-1:0] t;
        t = v[NormW-1] ? -v : v;
        return t[MagW-1:0];
    endfunction

    assign w_mx = mag(r_nx);
    assign w_my = mag(r_ny);
    assign w_mz = mag(r_nz);

    // operand select for the shared multiplier
    always_comb begin
        w_mag = w_mx;
        unique case (r_step)
            M_SYL, M_SYH, M_DY: w_mag = w_my;
            M_SZL, M_SZH, M_DZ: w_mag = w_mz;
            default:            w_mag = w_mx;
        endcase
        w_ma = MulAW'(w_mag);
        w_mb = '0;
        unique case (r_step)
            M_NX0: begin w_ma = MulAW'(i_tri.e0y); w_mb = MulBW'(i_tri.e1z); end
            M_NX1: begin w_ma = MulAW'(i_tri.e0z); w_mb = MulBW'(i_tri.e1y); end
            M_NY0: begin w_ma = MulAW'(i_tri.e0z); w_mb = MulBW'(i_tri.e1x); end
            M_NY1: begin w_ma = MulAW'(i_tri.e0x); w_mb = MulBW'(i_tri.e1z); end
            M_NZ0: begin w_ma = MulAW'(i_tri.e0x); w_mb = MulBW'(i_tri.e1y); end
            M_NZ1: begin w_ma = MulAW'(i_tri.e0y); w_mb = MulBW'(i_tri.e1x); end
            M_SXL, M_SYL, M_SZL: w_mb = MulBW'({1'b0, w_mag[16:0]});
            M_SXH, M_SYH, M_SZH: w_mb = MulBW'({1'b0, w_mag[33:17]});
            M_DX: begin w_ma = MulAW'(r_nx); w_mb = MulBW'(i_tri.ax); end
            M_DY: begin w_ma = MulAW'(r_ny); w_mb = MulBW'(i_tri.ay); end
            M_DZ: begin w_ma = MulAW'(r_nz); w_mb = MulBW'(i_tri.az); end
            default: w_mb = '0;
        endcase
    end

    // volume update with saturation
    always_comb begin
        w_contrib = i_flip ? -(DotW+1)'(r_dot) : (DotW+1)'(r_dot);
        w_vbase   = i_tri.first ? '0 : r_vol;
        w_vsum    = (VolW+1)'(w_vbase) + (VolW+1)'(w_contrib);
        w_vovf    = (w_vsum[VolW] != w_vsum[VolW-1]);
        if (w_vovf) begin
            w_vnew = w_vsum[VolW] ? {1'b1, {(VolW-1){1'b0}}} : {1'b0, {(VolW-1){1'b1}}};
        end else begin
            w_vnew = w_vsum[VolW-1:0];
        end
        w_vmag = w_vnew[VolW-1] ? VolW'(-w_vnew) : VolW'(w_vnew);
    end

    // one root bit per cycle
    always_comb begin
        w_trem  = {r_rem[RemW-3:0], r_rad[SqW-1:SqW-2]};
        w_trial = {1'b0, r_root, 2'b01};
    end

    // two quotient bits of the divide by three per cycle
    always_comb begin
        w_dnext = {r_drem, r_dq[VolW-1:VolW-2]};
        priority if (w_dnext >= 4'd9) w_qd = 2'd3;
        else if (w_dnext >= 4'd6)     w_qd = 2'd2;
        else if (w_dnext >= 4'd3)     w_qd = 2'd1;
        else                          w_qd = 2'd0;
    end

    always_comb begin
        w_asum = (AreaW+1)'(r_area) + (AreaW+1)'(r_root);
        w_aovf = w_asum[AreaW];
        w_anew = w_aovf ? {AreaW{1'b1}} : w_asum[AreaW-1:0];
        w_quot = r_dneg ? VolW'(-r_dq) : r_dq;
    end

    assign w_mul_done  = r_pvld && (r_pstep == M_DZ);
    assign w_iter_done = (r_iter == IterLast);
    assign w_out_free  = !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_tri_vld)    n_state = S_MUL;
            S_MUL:  if (w_mul_done)   n_state = S_UPD;
            S_UPD:                    n_state = S_ITER;
            S_ITER: if (w_iter_done)  n_state = S_FIN;
            S_FIN:  if (w_out_free)   n_state = S_IDLE;
            default:                  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_do_upd = (r_state == S_UPD);
        w_do_fin = (r_state == S_FIN) && w_out_free;
        o_pop    = w_do_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= M_NX0;
            r_pvld      <= 1'b0;
            r_iter      <= '0;
            r_area      <= '0;
            r_vol       <= '0;
            r_cnt       <= '0;
            r_sat       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pvld  <= (r_state == S_MUL) && (r_step != M_NONE);
            if (r_state == S_MUL && r_step != M_NONE) begin
                r_step <= t_step'(r_step + 4'd1);
            end else if (r_state != S_MUL) begin
                r_step <= M_NX0;
            end
            if (r_state == S_ITER) begin
                r_iter <= r_iter + 6'd1;
            end else begin
                r_iter <= '0;
            end
            if (w_do_upd) begin
                r_area <= i_tri.first ? '0 : r_area;
                r_vol  <= w_vnew;
                r_sat  <= (i_tri.first ? 1'b0 : r_sat) | w_vovf;
                if (i_tri.first) begin
                    r_cnt <= (CountMax != '0) ? CountW'(1) : '0;
                end else if (r_cnt < CountMax) begin
                    r_cnt <= r_cnt + CountW'(1);
                end
            end
            if (w_do_fin) begin
                r_area <= w_anew;
                r_sat  <= r_sat | w_aovf;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= w_ma * w_mb;
        r_pstep <= r_step;
        if (r_state == S_IDLE) begin
            r_sq <= '0;
        end
        if (r_pvld) begin
            unique case (r_pstep)
                M_NX0: r_nx <= r_prod[NormW-1:0];
                M_NX1: r_nx <= r_nx - r_prod[NormW-1:0];
                M_NY0: r_ny <= r_prod[NormW-1:0];
                M_NY1: r_ny <= r_ny - r_prod[NormW-1:0];
                M_NZ0: r_nz <= r_prod[NormW-1:0];
                M_NZ1: r_nz <= r_nz - r_prod[NormW-1:0];
                M_SXL, M_SYL, M_SZL: r_sq <= r_sq + SqW'(unsigned'(r_prod));
                M_SXH, M_SYH, M_SZH: r_sq <= r_sq + (SqW'(unsigned'(r_prod)) << 17);
                M_DX:  r_dot <= r_prod[DotW-1:0];
                M_DY, M_DZ: r_dot <= r_dot + r_prod[DotW-1:0];
                default: r_dot <= r_dot;
            endcase
        end
        if (w_do_upd) begin
            r_rad  <= r_sq;
            r_rem  <= '0;
            r_root <= '0;
            r_dq   <= {1'b0, w_vmag[VolW-1:1]};
            r_drem <= 2'd0;
            r_dneg <= w_vnew[VolW-1];
        end else if (r_state == S_ITER) begin
            r_rad <= {r_rad[SqW-3:0], 2'b00};
            if (w_trem >= w_trial) begin
                r_rem  <= w_trem - w_trial;
                r_root <= {r_root[RootW-2:0], 1'b1};
            end else begin
                r_rem  <= w_trem;
                r_root <= {r_root[RootW-2:0], 1'b0};
            end
            if (r_iter < 6'(DivSteps)) begin
                r_dq   <= {r_dq[VolW-3:0], w_qd};
                r_drem <= 2'(w_dnext - 4'(w_qd) * 4'd3);
            end
        end
        if (w_do_fin) begin
            o_running_area   <= w_anew;
            o_running_volume <= w_quot;
            o_triangle_count <= r_cnt;
            o_overflowed     <= r_sat | w_aovf;
        end
    end

endmodule

/* sim/tb_mesh_area_volume_accumulator_core.sv */
// Testbench for mesh_area_volume_accumulator_core: random and directed triangles, self-checking
`timescale 1ns / 1ps
module tb_mesh_area_volume_accumulator_core;
    import mava_pkg::*;

    localparam int MaxTri = 1048576;
    localparam longint unsigned RunLimit = 400000;
    localparam logic [AreaW-1:0] AreaMax = {AreaW{1'b1}};
    localparam logic signed [VolW-1:0] VolMax = {1'b0, {(VolW-1){1'b1}}};
    localparam logic signed [VolW-1:0] VolMin = {1'b1, {(VolW-1){1'b0}}};

    typedef struct packed {
        logic [AreaW-1:0]        area;
        logic signed [VolW-1:0]  vol;
        logic [CountW-1:0]       cnt;
        logic                    ovf;
    } t_mesh_sums;

    class mesh_sum_board;
        logic                    flip;
        logic [AreaW-1:0]        area_acc;
        logic signed [VolW-1:0]  vol6_acc;
        logic [CountW-1:0]       tri_cnt;
        logic                    sat;
        t_mesh_sums              pending_sums[$];
        int                      mismatches;
        int                      beats_out;

        function new();
            flip = 1'b0;
            area_acc = '0;
            vol6_acc = '0;
            tri_cnt = '0;
            sat = 1'b0;
            mismatches = 0;
            beats_out = 0;
        endfunction

        // v: ax ay az bx by bz cx cy cz
        function void note_triangle(logic first, logic [8:0][CoordW-1:0] v);
            longint ax, ay, az, e0x, e0y, e0z, e1x, e1y, e1z, nx, ny, nz, dot, contrib;
            logic [71:0] mx, my, mz, nsq, root, trial;
            logic [AreaW:0] asum;
            logic signed [VolW+1:0] vsum;
            t_mesh_sums s;
            ax = longint'($signed(v[8]));
            ay = longint'($signed(v[7]));
            az = longint'($signed(v[6]));
            e0x = longint'($signed(v[5])) - ax;
            e0y = longint'($signed(v[4])) - ay;
            e0z = longint'($signed(v[3])) - az;
            e1x = longint'($signed(v[2])) - ax;
            e1y = longint'($signed(v[1])) - ay;
            e1z = longint'($signed(v[0])) - az;
            nx = e0y * e1z - e0z * e1y;
            ny = e0z * e1x - e0x * e1z;
            nz = e0x * e1y - e0y * e1x;
            if (first) begin
                area_acc = '0;
                vol6_acc = '0;
                tri_cnt = '0;
                sat = 1'b0;
            end
            mx = 72'(nx < 0 ? -nx : nx);
            my = 72'(ny < 0 ? -ny : ny);
            mz = 72'(nz < 0 ? -nz : nz);
            nsq = mx * mx + my * my + mz * mz;
            root = '0;
            for (int b = 34; b >= 0; b--) begin
                trial = root | (72'd1 << b);
                if (trial * trial <= nsq) root = trial;
            end
            asum = {1'b0, area_acc} + root[AreaW:0];
            if (asum > {1'b0, AreaMax}) begin
                area_acc = AreaMax;
                sat = 1'b1;
            end else begin
                area_acc = asum[AreaW-1:0];
            end
            dot = nx * ax + ny * ay + nz * az;
            contrib = flip ? -dot : dot;
            vsum = (VolW+2)'(vol6_acc) + (VolW+2)'(contrib);
            if (vsum > (VolW+2)'(VolMax)) begin
                vol6_acc = VolMax;
                sat = 1'b1;
            end else if (vsum < (VolW+2)'(VolMin)) begin
                vol6_acc = VolMin;
                sat = 1'b1;
            end else begin
                vol6_acc = vsum[VolW-1:0];
            end
            if (tri_cnt < CountW'(MaxTri)) tri_cnt++;
            s.area = area_acc;
            s.vol = vol6_acc / 64'sd6;
            s.cnt = tri_cnt;
            s.ovf = sat;
            pending_sums.push_back(s);
        endfunction

        function void check_sums(t_mesh_sums got);
            t_mesh_sums want;
            beats_out++;
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output beat: area %0d vol %0d",
                                               got.area, got.vol);
                return;
            end
            want = pending_sums.pop_front();
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch beat %0d: area %0d/%0d vol %0d/%0d cnt %0d/%0d ovf %0b/%0b",
                             beats_out, want.area, got.area, want.vol, got.vol,
                             want.cnt, got.cnt, want.ovf, got.ovf);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_first_triangle = 1'b0;
    logic signed [CoordW-1:0] i_a_x = '0, i_a_y = '0, i_a_z = '0;
    logic signed [CoordW-1:0] i_b_x = '0, i_b_y = '0, i_b_z = '0;
    logic signed [CoordW-1:0] i_c_x = '0, i_c_y = '0, i_c_z = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [AreaW-1:0] o_running_area;
    logic signed [VolW-1:0] o_running_volume;
    logic [CountW-1:0] o_triangle_count;
    logic o_overflowed;

    mesh_sum_board board = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_req = 0;
    int stall_ack = 0;
    int stall_left = 0;
    longint unsigned cycles = 0;
    int tris_sent = 0;

    mesh_area_volume_accumulator_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_first_triangle(i_first_triangle),
        .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_c_x(i_c_x), .i_c_y(i_c_y), .i_c_z(i_c_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_running_area(o_running_area), .o_running_volume(o_running_volume),
        .o_triangle_count(o_triangle_count), .o_overflowed(o_overflowed)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RunLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("mesh_area_volume_accumulator_core verification failed");
            $finish;
        end
    end

    // receiver; long hold-off counted here
    always @(posedge i_clk) begin
        if (stall_req != stall_ack) begin
            stall_ack <= stall_req;
            stall_left <= 500;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_sums('{o_running_area, o_running_volume, o_triangle_count, o_overflowed});
    end

    task automatic send_tri(logic first, logic [8:0][CoordW-1:0] v);
        i_in_valid <= 1'b1;
        i_first_triangle <= first;
        {i_a_x, i_a_y, i_a_z, i_b_x, i_b_y, i_b_z, i_c_x, i_c_y, i_c_z} <= v;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_triangle(first, v);
        tris_sent++;
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
    endtask

    task automatic write_flip(logic val);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.flip = val;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending_sums.size() > 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic logic [CoordW-1:0] rand_coord(int style);
        case (style)
            0: return CoordW'($urandom_range(65535));
            1: return CoordW'($signed($urandom_range(512)) - 256);
            2: return ($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000;
            default: return CoordW'($signed($urandom_range(8192)) - 4096);
        endcase
    endfunction

    task automatic send_random(int n);
        logic [8:0][CoordW-1:0] v;
        int style;
        for (int k = 0; k < n; k++) begin
            style = $urandom_range(3);
            for (int j = 0; j < 9; j++) v[j] = rand_coord(style);
            if ($urandom_range(19) == 0) begin
                v[5:3] = v[8:6];
            end else if ($urandom_range(29) == 0) begin
                v[5:0] = {v[8:6], v[8:6]};
            end
            send_tri($urandom_range(24) == 0, v);
        end
    endtask

    initial begin
        logic [8:0][CoordW-1:0] v;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_flip(1'b0);
        tx_idle_pct = 34;
        rx_idle_pct = 59;

        send_tri(1'b1, {9{16'h0000}});
        send_tri(1'b0, {9{16'h8000}});
        send_tri(1'b0, {9{16'h7FFF}});
        send_tri(1'b0, {16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                        16'h8000, 16'h7FFF, 16'h8000});
        send_tri(1'b0, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                        16'h7FFF, 16'h7FFF, 16'h8000});
        send_tri(1'b0, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                        16'h8000, 16'h8000, 16'h7FFF});
        // unit triangle off origin, then the reversed winding
        send_tri(1'b1, {16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0100,
                        16'h0000, 16'h0100, 16'h0100});
        send_tri(1'b0, {16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0100,
                        16'h0100, 16'h0000, 16'h0100});
        // collinear, degenerate
        send_tri(1'b0, {16'h0001, 16'h0002, 16'h0003, 16'h0002, 16'h0004, 16'h0006,
                        16'h0003, 16'h0006, 16'h0009});
        send_tri(1'b0, {16'h1234, 16'hF00D, 16'h0042, 16'h1234, 16'hF00D, 16'h0042,
                        16'h1234, 16'hF00D, 16'h0042});
        send_tri(1'b0, {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                        16'hFFFF, 16'hFFFF, 16'h0001});
        send_tri(1'b1, {16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                        16'h0F0F, 16'hF0F0, 16'h00FF});
        send_random(200);
        drain();

        write_flip(1'b1);
        tx_idle_pct = 59;
        rx_idle_pct = 34;
        v = {16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000, 16'h0100,
             16'h0000, 16'h0100, 16'h0100};
        send_tri(1'b1, v);
        send_tri(1'b0, {9{16'h8000}});
        send_random(200);
        drain();

        write_flip(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_req = stall_req + 1;
        send_random(40);
        send_random(200);
        drain();

        $display("%0d triangles over both windings, sender/receiver idling and a long output stall",
                 tris_sent);
        $display("%0d result beats checked, %0d mismatches", board.beats_out, board.mismatches);
        if (board.mismatches == 0 && board.pending_sums.size() == 0)
            $display("mesh_area_volume_accumulator_core verification clean");
        else
            $display("mesh_area_volume_accumulator_core verification failed");
        $finish;
    end
endmodule
